/* hdl/clp_pkg.sv */
package clp_pkg;

  // code point and result widths
  localparam int unsigned CP_W    = 21;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 4;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // classification thresholds
  localparam logic [CP_W-1:0] UTF8_2_MIN  = 21'h00080;
  localparam logic [CP_W-1:0] UTF8_3_MIN  = 21'h00800;
  localparam logic [CP_W-1:0] WIDE_MIN    = 21'h10000;
  localparam logic [CP_W-1:0] HEX4_MIN    = 21'h00100;
  localparam logic [CP_W-1:0] CTRL_END    = 21'h00020;
  localparam logic [CP_W-1:0] DEL_CODE    = 21'h0007f;

  // named control characters
  localparam logic [CP_W-1:0] CP_BACKSPACE = 21'd8;
  localparam logic [CP_W-1:0] CP_TAB       = 21'd9;
  localparam logic [CP_W-1:0] CP_NEWLINE   = 21'd10;
  localparam logic [CP_W-1:0] CP_FORMFEED  = 21'd12;
  localparam logic [CP_W-1:0] CP_RETURN    = 21'd13;
  localparam logic [CP_W-1:0] CP_SPACE     = 21'd32;

  // UTF-8 lead and continuation prefixes
  localparam logic [BYTE_W-1:0] LEAD_2 = 8'hc0;
  localparam logic [BYTE_W-1:0] LEAD_3 = 8'he0;
  localparam logic [BYTE_W-1:0] LEAD_4 = 8'hf0;
  localparam logic [BYTE_W-1:0] CONT   = 8'h80;

  localparam logic [BYTE_W-1:0] CHR_BSLASH = 8'h5c;
  localparam logic [BYTE_W-1:0] CHR_U      = 8'h75;

  // names, left aligned and padded to ten characters
  localparam int unsigned NAME_CHARS = 10;
  localparam logic [NAME_CHARS*BYTE_W-1:0] STR_BACKSPACE = "\\backspace";
  localparam logic [NAME_CHARS*BYTE_W-1:0] STR_TAB       = "\\tab      ";
  localparam logic [NAME_CHARS*BYTE_W-1:0] STR_NEWLINE   = "\\newline  ";
  localparam logic [NAME_CHARS*BYTE_W-1:0] STR_FORMFEED  = "\\formfeed ";
  localparam logic [NAME_CHARS*BYTE_W-1:0] STR_RETURN    = "\\return   ";
  localparam logic [NAME_CHARS*BYTE_W-1:0] STR_SPACE     = "\\space    ";

  typedef enum logic [1:0] {
    KIND_UTF8,
    KIND_HEX,
    KIND_NAME,
    KIND_CHAR
  } kind_e;

  typedef enum logic [2:0] {
    NAME_BACKSPACE,
    NAME_TAB,
    NAME_NEWLINE,
    NAME_FORMFEED,
    NAME_RETURN,
    NAME_SPACE
  } name_e;

  // one classified request waiting for the back end
  typedef struct packed {
    kind_e             kind;
    name_e             name;
    logic [LEN_W-1:0]  len;
    logic [CP_W-1:0]   cp;
  } desc_t;

  // lower-case hex digit
  function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nib);
    logic [BYTE_W-1:0] res;
    if (nib < 4'd10) begin
      res = 8'h30 + {4'b0, nib};
    end else begin
      res = 8'h57 + {4'b0, nib};
    end
    return res;
  endfunction

  // one character of a control name
  function automatic logic [BYTE_W-1:0] name_char(input name_e nm,
                                                  input logic [LEN_W-1:0] idx);
    logic [NAME_CHARS*BYTE_W-1:0] str;
    logic [LEN_W-1:0]             pos;
    case (nm)
      NAME_BACKSPACE: str = STR_BACKSPACE;
      NAME_TAB:       str = STR_TAB;
      NAME_NEWLINE:   str = STR_NEWLINE;
      NAME_FORMFEED:  str = STR_FORMFEED;
      NAME_RETURN:    str = STR_RETURN;
      NAME_SPACE:     str = STR_SPACE;
      default:        str = STR_SPACE;
    endcase
    pos = LEN_W'(NAME_CHARS - 1) - idx;
    return str[pos*BYTE_W +: BYTE_W];
  endfunction

endpackage

/* hdl/char_literal_printer.sv */
// channel   direction  handshake     payload
// input     in         push / full   code_point_i[20:0]
// result    out        pop / empty   out_byte_o[7:0], last_byte_o
// config    in         cfg_we_i      cfg_wdata_i (readable mode)
//
// each code point gives one to ten result bytes, one byte per cycle unless the
// result port stalls; a code point is classified on entry and waits in a small
// queue for the byte generator; the first byte goes from the queue head into the
// output register, which drives the result ports
// reset empties the queue and output register and selects readable mode
// a stalled result port holds the byte; input keeps filling until the queue is full
module char_literal_printer #(
  parameter int unsigned QueueDepth = clp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic [20:0] code_point_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic        last_byte_o
);
  import clp_pkg::*;

  desc_t front_desc, q_desc;
  logic  q_valid, q_pop;

  // classification
  clp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .code_point_i (code_point_i),
    .desc_o       (front_desc)
  );

  // request queue between front and back
  clp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (push),
    .wdata_i (front_desc),
    .full_o  (full),
    .rd_i    (q_pop),
    .rdata_o (q_desc),
    .valid_o (q_valid)
  );

  // byte generation
  clp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_i       (q_desc),
    .desc_valid_i (q_valid),
    .desc_pop_o   (q_pop),
    .empty        (empty),
    .pop          (pop),
    .out_byte_o   (out_byte_o),
    .last_byte_o  (last_byte_o)
  );

endmodule

/* hdl/clp_front.sv */
module clp_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  input  logic [20:0]   code_point_i,
  output clp_pkg::desc_t desc_o
);
  import clp_pkg::*;

  logic readable_q;
  desc_t d;

  // mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      readable_q <= 1'b1;
    end else if (cfg_we_i) begin
      readable_q <= cfg_wdata_i;
    end
  end

  // classify the code point and count its bytes
  always_comb begin
    d.cp   = code_point_i;
    d.name = NAME_SPACE;
    d.kind = KIND_UTF8;
    d.len  = LEN_W'(1);
    if (!readable_q) begin
      d.kind = KIND_UTF8;
      if (code_point_i < UTF8_2_MIN) begin
        d.len = LEN_W'(1);
      end else if (code_point_i < UTF8_3_MIN) begin
        d.len = LEN_W'(2);
      end else if (code_point_i < WIDE_MIN) begin
        d.len = LEN_W'(3);
      end else begin
        d.len = LEN_W'(4);
      end
    end else if (code_point_i >= WIDE_MIN) begin
      d.kind = KIND_HEX;
      d.len  = LEN_W'(8);
    end else if (code_point_i >= HEX4_MIN) begin
      d.kind = KIND_HEX;
      d.len  = LEN_W'(6);
    end else if (code_point_i == CP_BACKSPACE) begin
      d.kind = KIND_NAME;
      d.name = NAME_BACKSPACE;
      d.len  = LEN_W'(10);
    end else if (code_point_i == CP_TAB) begin
      d.kind = KIND_NAME;
      d.name = NAME_TAB;
      d.len  = LEN_W'(4);
    end else if (code_point_i == CP_NEWLINE) begin
      d.kind = KIND_NAME;
      d.name = NAME_NEWLINE;
      d.len  = LEN_W'(8);
    end else if (code_point_i == CP_FORMFEED) begin
      d.kind = KIND_NAME;
      d.name = NAME_FORMFEED;
      d.len  = LEN_W'(9);
    end else if (code_point_i == CP_RETURN) begin
      d.kind = KIND_NAME;
      d.name = NAME_RETURN;
      d.len  = LEN_W'(7);
    end else if (code_point_i == CP_SPACE) begin
      d.kind = KIND_NAME;
      d.name = NAME_SPACE;
      d.len  = LEN_W'(6);
    end else if (code_point_i < CTRL_END || code_point_i >= DEL_CODE) begin
      d.kind = KIND_HEX;
      d.len  = LEN_W'(4);
    end else begin
      d.kind = KIND_CHAR;
      d.len  = LEN_W'(2);
    end
  end

  assign desc_o = d;

endmodule

/* hdl/clp_queue.sv */
module clp_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  clp_pkg::desc_t wdata_i,
  output logic           full_o,
  input  logic           rd_i,
  output clp_pkg::desc_t rdata_o,
  output logic           valid_o
);
  import clp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  desc_t            mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && valid_o;
  assign rdata_o = mem_q[rptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_rd) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

/* hdl/clp_back.sv */
module clp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  clp_pkg::desc_t desc_i,
  input  logic           desc_valid_i,
  output logic           desc_pop_o,
  output logic           empty,
  input  logic           pop,
  output logic [7:0]     out_byte_o,
  output logic           last_byte_o
);
  import clp_pkg::*;

  logic [LEN_W-1:0]  idx_q, idx_d;
  logic              valid_q, valid_d;
  logic [BYTE_W-1:0] byte_q, byte_d;
  logic              last_q, last_d;
  logic [BYTE_W-1:0] cur_byte;
  logic              cur_last;
  logic              advance;
  logic [LEN_W-1:0]  rpos;
  logic [23:0]       cp_ext;

  assign cp_ext   = {3'b0, desc_i.cp};
  assign rpos     = desc_i.len - LEN_W'(1) - idx_q;
  assign cur_last = (rpos == '0);

  // byte at the current position
  always_comb begin
    cur_byte = CHR_BSLASH;
    case (desc_i.kind)
      KIND_UTF8: begin
        if (idx_q != '0) begin
          cur_byte = CONT | {2'b0, cp_ext[rpos[1:0]*6 +: 6]};
        end else begin
          case (desc_i.len)
            LEN_W'(2): cur_byte = LEAD_2 | {3'b0, desc_i.cp[10:6]};
            LEN_W'(3): cur_byte = LEAD_3 | {4'b0, desc_i.cp[15:12]};
            LEN_W'(4): cur_byte = LEAD_4 | {5'b0, desc_i.cp[20:18]};
            default:   cur_byte = desc_i.cp[7:0];
          endcase
        end
      end
      KIND_HEX: begin
        if (idx_q == LEN_W'(0)) begin
          cur_byte = CHR_BSLASH;
        end else if (idx_q == LEN_W'(1)) begin
          cur_byte = CHR_U;
        end else begin
          cur_byte = hex_char(cp_ext[rpos[2:0]*4 +: 4]);
        end
      end
      KIND_NAME: cur_byte = name_char(desc_i.name, idx_q);
      KIND_CHAR: cur_byte = (idx_q == '0) ? CHR_BSLASH : desc_i.cp[7:0];
      default:   cur_byte = CHR_BSLASH;
    endcase
  end

  // output register, refilled whenever it is free or being taken
  always_comb begin
    advance    = !valid_q || pop;
    valid_d    = valid_q;
    byte_d     = byte_q;
    last_d     = last_q;
    idx_d      = idx_q;
    desc_pop_o = 1'b0;
    if (advance) begin
      valid_d = desc_valid_i;
      if (desc_valid_i) begin
        byte_d = cur_byte;
        last_d = cur_last;
        if (cur_last) begin
          idx_d      = '0;
          desc_pop_o = 1'b1;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign empty       = !valid_q;
  assign out_byte_o  = byte_q;
  assign last_byte_o = last_q;

endmodule
